/* rtl/core/mssb_pkg.sv */
// ----------------------------------------------------------------------------
// mssb_pkg
// Types, codes and the digit table shared by the seven-segment blinker.
// ----------------------------------------------------------------------------
`default_nettype none

package mssb_pkg;

    localparam int unsigned DIGIT_W  = 3;
    localparam int unsigned SEG_W    = 8;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_WRITE_CHR = 2'd1,
        CMD_WRITE_RAW = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_POS  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_STEADY    = 2'd0,
        MODE_BLINK_ALL = 2'd1,
        MODE_BLINK_ONE = 2'd2,
        MODE_DOT_RANGE = 2'd3
    } blink_mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_DIGIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_FIRST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_SPAN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_DIGIT    = 3'd6;

    localparam logic [7:0]       CHR_SPACE = 8'h20;
    localparam logic [7:0]       CHR_ZERO  = 8'h30;
    localparam logic [7:0]       CHR_NINE  = 8'h39;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_DOT   = 8'h80;
    localparam logic [SEG_W-1:0] SEG_ALL   = 8'hFF;

    // decimal digit to segments, bit0 = a .. bit6 = g
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        begin
            case (d)
                4'd0: s = 8'h3f;
                4'd1: s = 8'h06;
                4'd2: s = 8'h5b;
                4'd3: s = 8'h4f;
                4'd4: s = 8'h66;
                4'd5: s = 8'h6d;
                4'd6: s = 8'h7d;
                4'd7: s = 8'h07;
                4'd8: s = 8'h7f;
                4'd9: s = 8'h6f;
                default: s = SEG_BLANK;
            endcase
            seg_code = s;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/multiplexed_seven_segment_blinker.sv */
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_blinker
// Multiplexed seven-segment refresher with digit store and blink modes.
// ----------------------------------------------------------------------------
//  channel  | direction | tuser                    | tdata
//  s_axis   | in        | [1:0] cmd                | [2:0] digit_pos, [10:3] char_or_segments
//  m_axis   | out       | [1:0] status, [2] drive_valid | [2:0] drive_digit, [10:3] segments
//  cfg      | in        | -                        | cfg_index, cfg_wdata, write on cfg_wr_en
//
// One item per cycle while s_axis_tready is high; the result appears in the
// output register in the cycle after the item is taken. The digit store,
// scan and blink state update at the accept edge. s_axis_tready stays high
// while the output register is empty or being drained. aresetn is synchronous,
// clears all state but the output data, digit store included; config gets defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_blinker
    import mssb_pkg::*;
#(
    parameter int unsigned MAX_DIGIT_COUNT = 8
) (
    input  wire                   aclk,
    input  wire                   aresetn,

    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [15:0]           s_axis_tdata,   // [2:0] digit_pos, [10:3] char_or_segments
    input  wire  [1:0]            s_axis_tuser,   // [1:0] cmd

    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [2:0] drive_digit, [10:3] segments
    output logic [7:0]            m_axis_tuser,   // [1:0] status, [2] drive_valid

    input  wire                   cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned IDX_W = (MAX_DIGIT_COUNT > 1) ? $clog2(MAX_DIGIT_COUNT) : 1;
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGIT_COUNT);

    // configuration
    logic [COUNT_W-1:0]  digit_count_reg;
    logic [1:0]          blink_mode_reg;
    logic [PERIOD_W-1:0] blink_period_reg;
    logic [DIGIT_W-1:0]  blink_digit_reg;
    logic [DIGIT_W-1:0]  dot_first_reg;
    logic [COUNT_W-1:0]  dot_span_reg;
    logic [COUNT_W-1:0]  dot_digit_reg;

    // state
    logic [SEG_W-1:0]    store_reg [MAX_DIGIT_COUNT];
    logic [DIGIT_W-1:0]  scan_reg,  scan_next;
    logic [PERIOD_W-1:0] bcnt_reg,  bcnt_next;
    logic                phase_reg, phase_next;

    // output register
    logic                out_valid_reg;
    logic [1:0]          out_status_reg,  out_status_next;
    logic                out_drive_reg,   out_drive_next;
    logic [DIGIT_W-1:0]  out_digit_reg,   out_digit_next;
    logic [SEG_W-1:0]    out_seg_reg,     out_seg_next;

    // item fields
    cmd_t             in_cmd;
    logic [DIGIT_W-1:0] in_pos;
    logic [7:0]       in_chr;
    logic             accept;

    logic [COUNT_W-1:0] count_eff;
    logic [DIGIT_W-1:0] scan_cur;
    logic [COUNT_W-1:0] scan_inc;
    logic [SEG_W-1:0]   seg_raw;
    logic [SEG_W-1:0]   seg_show;
    logic [DIGIT_W+1:0] dot_end;
    logic               in_dot_range;
    logic [PERIOD_W-1:0] bcnt_inc;
    logic               pos_bad;
    logic               chr_digit;
    logic               store_we;
    logic [SEG_W-1:0]   store_wdata;
    logic               clear_all;
    logic               cfg_clr_phase;
    logic               cfg_clr_cnt;

    assign in_cmd = cmd_t'(s_axis_tuser);
    assign in_pos = s_axis_tdata[2:0];
    assign in_chr = s_axis_tdata[10:3];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_seg_reg, out_digit_reg};
    assign m_axis_tuser  = {5'b0, out_drive_reg, out_status_reg};

    // blink mode writes clear counter and phase, period writes clear the counter
    assign cfg_clr_phase = cfg_wr_en && (cfg_index == REG_BLINK_MODE);
    assign cfg_clr_cnt   = cfg_clr_phase || (cfg_wr_en && (cfg_index == REG_BLINK_PERIOD));

    always_comb begin
        // zero acts as one, values above the store depth clamp to it
        if (digit_count_reg == '0) begin
            count_eff = COUNT_W'(1);
        end else if (digit_count_reg > MAX_CNT) begin
            count_eff = MAX_CNT;
        end else begin
            count_eff = digit_count_reg;
        end

        scan_cur = ({1'b0, scan_reg} >= count_eff) ? '0 : scan_reg;
        scan_inc = {1'b0, scan_cur} + COUNT_W'(1);

        seg_raw      = store_reg[scan_cur[IDX_W-1:0]];
        dot_end      = {2'b0, dot_first_reg} + {1'b0, dot_span_reg};
        in_dot_range = (scan_cur >= dot_first_reg) && ({2'b0, scan_cur} < dot_end);

        seg_show = seg_raw;
        if (phase_reg) begin
            case (blink_mode_t'(blink_mode_reg))
                MODE_STEADY:    seg_show = seg_raw;
                MODE_BLINK_ALL: seg_show = SEG_BLANK;
                MODE_BLINK_ONE: seg_show = (scan_cur == blink_digit_reg) ? SEG_BLANK : seg_raw;
                MODE_DOT_RANGE: seg_show = in_dot_range ? (seg_raw | SEG_DOT) : seg_raw;
                default:        seg_show = seg_raw;
            endcase
        end
        // steady dot applies in every mode and phase
        if (!dot_digit_reg[3] && (scan_cur == dot_digit_reg[2:0])) begin
            seg_show = seg_show | SEG_DOT;
        end

        bcnt_inc  = bcnt_reg + PERIOD_W'(1);
        pos_bad   = {1'b0, in_pos} >= count_eff;
        chr_digit = (in_chr >= CHR_ZERO) && (in_chr <= CHR_NINE);

        scan_next       = scan_reg;
        bcnt_next       = bcnt_reg;
        phase_next      = phase_reg;
        out_status_next = ST_OK;
        out_drive_next  = 1'b0;
        out_digit_next  = '0;
        out_seg_next    = SEG_BLANK;
        store_we        = 1'b0;
        store_wdata     = SEG_BLANK;
        clear_all       = 1'b0;

        case (in_cmd)
            CMD_TICK: begin
                out_drive_next = 1'b1;
                out_digit_next = scan_cur;
                out_seg_next   = seg_show;
                scan_next      = (scan_inc >= count_eff) ? '0 : scan_inc[DIGIT_W-1:0];
                if (blink_mode_t'(blink_mode_reg) != MODE_STEADY) begin
                    if (bcnt_inc >= blink_period_reg) begin
                        bcnt_next  = '0;
                        phase_next = !phase_reg;
                    end else begin
                        bcnt_next = bcnt_inc;
                    end
                end
            end
            CMD_WRITE_CHR: begin
                if (pos_bad) begin
                    out_status_next = ST_BAD_POS;
                end else if (in_chr == CHR_SPACE) begin
                    store_we = 1'b1;
                end else if (chr_digit) begin
                    store_we    = 1'b1;
                    store_wdata = seg_code(in_chr[3:0]);
                end else begin
                    out_status_next = ST_BAD_CHAR;
                end
            end
            CMD_WRITE_RAW: begin
                if (pos_bad) begin
                    out_status_next = ST_BAD_POS;
                end else begin
                    store_we    = 1'b1;
                    store_wdata = in_chr & SEG_ALL;
                end
            end
            CMD_CLEAR: begin
                clear_all = 1'b1;
                scan_next = '0;
            end
            default: begin
                out_status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg  <= COUNT_W'(4);
            blink_mode_reg   <= MODE_STEADY;
            blink_period_reg <= '0;
            blink_digit_reg  <= '0;
            dot_first_reg    <= '0;
            dot_span_reg     <= '0;
            dot_digit_reg    <= COUNT_W'(15);
            scan_reg         <= '0;
            bcnt_reg         <= '0;
            phase_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_DIGIT_COUNT; i++) begin
                store_reg[i] <= SEG_BLANK;
            end
        end else begin
            if (accept) begin
                scan_reg <= scan_next;
                if (clear_all) begin
                    for (int i = 0; i < MAX_DIGIT_COUNT; i++) begin
                        store_reg[i] <= SEG_BLANK;
                    end
                end else if (store_we) begin
                    store_reg[in_pos[IDX_W-1:0]] <= store_wdata;
                end
            end

            if (cfg_clr_cnt) begin
                bcnt_reg <= '0;
            end else if (accept) begin
                bcnt_reg <= bcnt_next;
            end

            if (cfg_clr_phase) begin
                phase_reg <= 1'b0;
            end else if (accept) begin
                phase_reg <= phase_next;
            end

            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DIGIT_COUNT:  digit_count_reg  <= cfg_wdata[COUNT_W-1:0];
                    REG_BLINK_MODE:   blink_mode_reg   <= cfg_wdata[1:0];
                    REG_BLINK_PERIOD: blink_period_reg <= cfg_wdata[PERIOD_W-1:0];
                    REG_BLINK_DIGIT:  blink_digit_reg  <= cfg_wdata[DIGIT_W-1:0];
                    REG_DOT_FIRST:    dot_first_reg    <= cfg_wdata[DIGIT_W-1:0];
                    REG_DOT_SPAN:     dot_span_reg     <= cfg_wdata[COUNT_W-1:0];
                    REG_DOT_DIGIT:    dot_digit_reg    <= cfg_wdata[COUNT_W-1:0];
                    default: begin
                        digit_count_reg <= digit_count_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= out_status_next;
            out_drive_reg  <= out_drive_next;
            out_digit_reg  <= out_digit_next;
            out_seg_reg    <= out_seg_next;
        end
    end

endmodule

`default_nettype wire
